// ===== rtl/assert_macros.svh =====
// assertion helpers for the checker file
// both macros sample on clk and are held off while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SVG_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svg check failed");

// next-cycle implication
`define SVG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("svg check failed");

`endif

// ===== rtl/svg_pkg.sv =====
// ----------------------------------------------------------------------------
// svg_pkg
// Shared types, grid constants and elaboration-time sine/cosine builders
// for the sphere vertex generator.
// ----------------------------------------------------------------------------
`default_nettype none

package svg_pkg;

  // grid size
  localparam int STACKS = 32;
  localparam int SLICES = 16;

  localparam int LON_W = 6;
  localparam int LAT_W = 5;
  localparam int LON_ENTRIES = 1 << LON_W;
  localparam int LAT_ENTRIES = 1 << LAT_W;

  localparam int RADIUS_W = 16;
  localparam int COORD_W  = 17;
  localparam int MAG_W    = 31;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd256;

  // pi in Q2.30 and 1.0 in Q2.30
  localparam longint unsigned PI_Q30  = 64'd3373259426;
  localparam longint          ONE_Q30 = 64'sd1073741824;

  // sine and cosine as sign and magnitude, magnitude in Q1.30
  typedef struct packed {
    logic             sin_neg;
    logic [MAG_W-1:0] sin_mag;
    logic             cos_neg;
    logic [MAG_W-1:0] cos_mag;
  } svg_trig_t;

  // longitude phase in 2^-32 turn, rounded to nearest
  function automatic logic [31:0] lon_phase(input logic [LON_W-1:0] idx);
    longint unsigned p;
    p = ((64'(idx) << 32) + 64'(STACKS / 2)) / 64'(STACKS);
    return p[31:0];
  endfunction

  // latitude phase, starting at the south pole
  function automatic logic [31:0] lat_phase(input logic [LAT_W-1:0] idx);
    longint unsigned p;
    p = ((64'(idx) << 31) + 64'(SLICES / 2)) / 64'(SLICES);
    return 32'hC000_0000 + p[31:0];
  endfunction

  // taylor sine and cosine of a phase, evaluated only at elaboration
  function automatic svg_trig_t trig_of_phase(input logic [31:0] ph);
    logic [1:0]      quad;
    logic [29:0]     f;
    longint unsigned u;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint          s;
    longint          c;
    longint          s0;
    longint          c0;
    longint          sn;
    longint          cs;
    svg_trig_t       res;
    quad = ph[31:30];
    f    = ph[29:0];
    // fold into the first octant
    if (f < 30'h2000_0000) begin
      u = 64'(f);
    end else begin
      u = 64'h4000_0000 - 64'(f);
    end
    x  = (u * PI_Q30) >> 31;
    x2 = (x * x) >> 30;
    // sine series
    t = x;
    s = longint'(x);
    t = ((t * x2) >> 30) / 64'd6;   s = s - longint'(t);
    t = ((t * x2) >> 30) / 64'd20;  s = s + longint'(t);
    t = ((t * x2) >> 30) / 64'd42;  s = s - longint'(t);
    t = ((t * x2) >> 30) / 64'd72;  s = s + longint'(t);
    t = ((t * x2) >> 30) / 64'd110; s = s - longint'(t);
    // cosine series
    t = 64'(ONE_Q30);
    c = ONE_Q30;
    t = ((t * x2) >> 30) / 64'd2;   c = c - longint'(t);
    t = ((t * x2) >> 30) / 64'd12;  c = c + longint'(t);
    t = ((t * x2) >> 30) / 64'd30;  c = c - longint'(t);
    t = ((t * x2) >> 30) / 64'd56;  c = c + longint'(t);
    t = ((t * x2) >> 30) / 64'd90;  c = c - longint'(t);
    // clamp to [0, 1]
    if (s < 0) s = 0;
    if (s > ONE_Q30) s = ONE_Q30;
    if (c < 0) c = 0;
    if (c > ONE_Q30) c = ONE_Q30;
    // undo the octant fold
    if (f < 30'h2000_0000) begin
      s0 = s;
      c0 = c;
    end else begin
      s0 = c;
      c0 = s;
    end
    // quadrant signs
    case (quad)
      2'd0: begin
        sn = s0;  cs = c0;
      end
      2'd1: begin
        sn = c0;  cs = -s0;
      end
      2'd2: begin
        sn = -s0; cs = -c0;
      end
      default: begin
        sn = -c0; cs = s0;
      end
    endcase
    res.sin_neg = (sn < 0);
    res.sin_mag = (sn < 0) ? MAG_W'(-sn) : MAG_W'(sn);
    res.cos_neg = (cs < 0);
    res.cos_mag = (cs < 0) ? MAG_W'(-cs) : MAG_W'(cs);
    return res;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sphere_vertex_generator_core.sv =====
// Sphere vertex generator: one point of a longitude/latitude sphere per beat.
// Input stream in_*: in_tdata carries lon_step and lat_step; output stream
// out_*: out_tdata carries x, y, z as signed Q8.8. The radius (unsigned
// Q8.8) is written through cfg_wr_en/cfg_wr_data and should only change
// while no beat is in flight.
// An input beat passes table lookup, factor multiply, factor round, radius
// multiply and radius round to the output beat. Throughput is one beat per
// cycle unless the output stalls; the two chained multiplies set the stage count.
// All stages advance together. When out_tvalid is high and out_tready is
// low the whole pipeline holds and in_tready drops, so nothing is lost or
// repeated; otherwise in_tready stays high, also while a result is taken
// in the same cycle.
// Synchronous active-low reset clears every stage valid and sets the radius
// to 1.0 (256); the pipeline is ready as soon as reset is released.
// ----------------------------------------------------------------------------
// sphere_vertex_generator_core
// Top level: handshake, stage valids, radius register and the multiply chain.
// ----------------------------------------------------------------------------
`default_nettype none

module sphere_vertex_generator_core
  import svg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [15:0] in_tdata,    // [5:0] lon_step, [10:6] lat_step
  // output stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [55:0] out_tdata,   // [16:0] x_coord, [33:17] y_coord, [50:34] z_coord
  // radius register
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);

  localparam int STAGES = 5;

  logic [STAGES-1:0]   vld_r;
  logic [STAGES-1:0]   vld_nxt;
  logic                en;
  logic [RADIUS_W-1:0] radius_r;
  logic [MAG_W-1:0]    radius_mag;

  svg_trig_t lon_lut;
  svg_trig_t lat_lut;
  svg_trig_t lon_trig_r;
  svg_trig_t lat_trig_r;

  logic [MAG_W-1:0] xf_mag;
  logic             xf_neg;
  logic [MAG_W-1:0] zf_mag;
  logic             zf_neg;
  logic [MAG_W-1:0] yr_mag;
  logic             yr_neg;
  logic [MAG_W-1:0] xo_mag;
  logic             xo_neg;
  logic [MAG_W-1:0] zo_mag;
  logic             zo_neg;

  logic [COORD_W-1:0] y_d1_r;
  logic               y_neg_d1_r;
  logic [COORD_W-1:0] y_d2_r;
  logic               y_neg_d2_r;

  logic [COORD_W-1:0] x_coord;
  logic [COORD_W-1:0] y_coord;
  logic [COORD_W-1:0] z_coord;

  // global advance: move when the last stage is empty or drained
  assign en        = ~vld_r[STAGES-1] | out_tready;
  assign in_tready = en;

  always_comb begin
    vld_nxt = {vld_r[STAGES-2:0], in_tvalid};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_nxt;
    end
  end

  // radius register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_wr_en) begin
      radius_r <= cfg_wr_data;
    end
  end

  assign radius_mag = MAG_W'(radius_r);

  // stage 1: sine/cosine lookup
  svg_trig_lut u_lut (
    .lon_step (in_tdata[5:0]),
    .lat_step (in_tdata[10:6]),
    .lon_trig (lon_lut),
    .lat_trig (lat_lut)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      lon_trig_r <= lon_lut;
      lat_trig_r <= lat_lut;
    end
  end

  // stages 2-3: cos(lat)*cos(lon), cos(lat)*sin(lon), r*sin(lat)
  svg_mag_mul u_xf (
    .clk     (clk),
    .en      (en),
    .a_mag   (lat_trig_r.cos_mag),
    .b_mag   (lon_trig_r.cos_mag),
    .neg_in  (lat_trig_r.cos_neg ^ lon_trig_r.cos_neg),
    .mag_out (xf_mag),
    .neg_out (xf_neg)
  );

  svg_mag_mul u_zf (
    .clk     (clk),
    .en      (en),
    .a_mag   (lat_trig_r.cos_mag),
    .b_mag   (lon_trig_r.sin_mag),
    .neg_in  (lat_trig_r.cos_neg ^ lon_trig_r.sin_neg),
    .mag_out (zf_mag),
    .neg_out (zf_neg)
  );

  svg_mag_mul u_yr (
    .clk     (clk),
    .en      (en),
    .a_mag   (radius_mag),
    .b_mag   (lat_trig_r.sin_mag),
    .neg_in  (lat_trig_r.sin_neg),
    .mag_out (yr_mag),
    .neg_out (yr_neg)
  );

  // stages 4-5: scale x and z factors by the radius
  svg_mag_mul u_xo (
    .clk     (clk),
    .en      (en),
    .a_mag   (radius_mag),
    .b_mag   (xf_mag),
    .neg_in  (xf_neg),
    .mag_out (xo_mag),
    .neg_out (xo_neg)
  );

  svg_mag_mul u_zo (
    .clk     (clk),
    .en      (en),
    .a_mag   (radius_mag),
    .b_mag   (zf_mag),
    .neg_in  (zf_neg),
    .mag_out (zo_mag),
    .neg_out (zo_neg)
  );

  // y is done early, delay it to line up with x and z
  always_ff @(posedge clk) begin
    if (en) begin
      y_d1_r     <= yr_mag[COORD_W-1:0];
      y_neg_d1_r <= yr_neg;
      y_d2_r     <= y_d1_r;
      y_neg_d2_r <= y_neg_d1_r;
    end
  end

  // apply signs, magnitudes stay within 16 bits
  assign x_coord = xo_neg ? (COORD_W'(0) - xo_mag[COORD_W-1:0]) : xo_mag[COORD_W-1:0];
  assign y_coord = y_neg_d2_r ? (COORD_W'(0) - y_d2_r) : y_d2_r;
  assign z_coord = zo_neg ? (COORD_W'(0) - zo_mag[COORD_W-1:0]) : zo_mag[COORD_W-1:0];

  assign out_tvalid = vld_r[STAGES-1];
  assign out_tdata  = {5'b0, z_coord, y_coord, x_coord};

endmodule

`default_nettype wire

// ===== rtl/svg_trig_lut.sv =====
// ----------------------------------------------------------------------------
// svg_trig_lut
// Constant sine/cosine tables for every longitude and latitude index,
// built at elaboration and read combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module svg_trig_lut
  import svg_pkg::*;
(
  input  wire logic [LON_W-1:0] lon_step,
  input  wire logic [LAT_W-1:0] lat_step,
  output svg_trig_t             lon_trig,
  output svg_trig_t             lat_trig
);

  svg_trig_t lon_tbl [LON_ENTRIES];
  svg_trig_t lat_tbl [LAT_ENTRIES];

  // longitude table, indexes past the grid wrap around the turn
  for (genvar g = 0; g < LON_ENTRIES; g++) begin : g_lon
    localparam svg_trig_t ENT = trig_of_phase(lon_phase(LON_W'(g)));
    assign lon_tbl[g] = ENT;
  end

  // latitude table
  for (genvar g = 0; g < LAT_ENTRIES; g++) begin : g_lat
    localparam svg_trig_t ENT = trig_of_phase(lat_phase(LAT_W'(g)));
    assign lat_tbl[g] = ENT;
  end

  assign lon_trig = lon_tbl[lon_step];
  assign lat_trig = lat_tbl[lat_step];

endmodule

`default_nettype wire

// ===== rtl/svg_mag_mul.sv =====
// ----------------------------------------------------------------------------
// svg_mag_mul
// Two-stage sign/magnitude multiply by a Q1.30 factor: product register,
// then round half away from zero back to the scale of the first operand.
// ----------------------------------------------------------------------------
`default_nettype none

module svg_mag_mul
  import svg_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [MAG_W-1:0] a_mag,
  input  wire logic [MAG_W-1:0] b_mag,
  input  wire logic             neg_in,
  output logic      [MAG_W-1:0] mag_out,
  output logic                  neg_out
);

  localparam int PROD_W = 2 * MAG_W;
  localparam logic [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << 29;

  logic [PROD_W-1:0] prod_r;
  logic              neg1_r;
  logic [PROD_W-1:0] rounded;
  logic [MAG_W-1:0]  mag_r;
  logic              neg2_r;

  // stage a: raw product
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= PROD_W'(a_mag) * PROD_W'(b_mag);
      neg1_r <= neg_in;
    end
  end

  // stage b: round and rescale
  assign rounded = (prod_r + ROUND_HALF) >> 30;

  always_ff @(posedge clk) begin
    if (en) begin
      mag_r  <= rounded[MAG_W-1:0];
      neg2_r <= neg1_r;
    end
  end

  assign mag_out = mag_r;
  assign neg_out = neg2_r;

endmodule

`default_nettype wire

// ===== rtl/svg_checker.sv =====
// ----------------------------------------------------------------------------
// svg_checker
// Port-level checks for the sphere vertex generator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module svg_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [55:0] out_tdata
);

  // a stalled output beat stays and holds its data
  `SVG_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))

  // the pipeline only stops taking beats when the output is blocked
  `SVG_ASSERT_SAME(a_ready_rule, 1'b1, in_tready == (!out_tvalid || out_tready))

  // coordinates never reach -65536, every factor is at most 1.0
  `SVG_ASSERT_SAME(a_xy_range, out_tvalid,
                   out_tdata[16:0] != 17'h10000 && out_tdata[33:17] != 17'h10000)
  `SVG_ASSERT_SAME(a_z_range, out_tvalid, out_tdata[50:34] != 17'h10000)

endmodule

bind sphere_vertex_generator_core svg_checker u_svg_checker (.*);

`default_nettype wire
